[rtl/mcmc_sst_pkg.sv]
// Shared types and constants of the step-size bisection tuner.
`default_nettype none

package mcmc_sst_pkg;

	// transaction kind
	localparam logic MODE_TRIAL   = 1'b0;
	localparam logic MODE_RESTART = 1'b1;

	// tuning stage per parameter
	localparam logic [1:0] STAGE_SEARCH = 2'd0;
	localparam logic [1:0] STAGE_BISECT = 2'd1;
	localparam logic [1:0] STAGE_DONE   = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_TARGET_P0  = 3'd0;
	localparam logic [2:0] REG_TARGET_P1  = 3'd1;
	localparam logic [2:0] REG_TARGET_P2  = 3'd2;
	localparam logic [2:0] REG_TARGET_P3  = 3'd3;
	localparam logic [2:0] REG_ERROR_COEF = 3'd4;
	localparam logic [2:0] REG_MIN_TRIALS = 3'd5;

	localparam int NUM_TARGETS = 4;

	localparam logic [15:0] TARGET_RST     = 16'd32768;
	localparam logic [15:0] ERROR_COEF_RST = 16'd8192;
	localparam logic [23:0] MIN_TRIALS_RST = 24'd10000;

	// request to the significance unit
	typedef struct packed {
		logic        start;
		logic [31:0] n;
		logic [31:0] accepts;
		logic [15:0] target;
		logic [15:0] coeff;
	} core_req_t;

	// verdict of the significance unit
	typedef struct packed {
		logic done;
		logic below;
		logic above;
	} core_res_t;

endpackage

`default_nettype wire

[rtl/mcmc_step_size_bisection_tuner.sv]
// Top level of the step-size bisection tuner: parameter state, configuration, sequencer, I/O.
// A trial transaction reads and bumps the tallies in the load step, waits in the significance
// unit (a single registered 32x32 multiplier used six times, two accumulate steps and a compare;
// the stage rule is applied as its verdict arrives) and then loads the output register. Restart
// and out-of-range transactions go from the load step straight to the output step. in_ready is
// high only between transactions, so a new transaction is accepted only once the last one is
// through; a result waiting on out_ready holds the block in its output step.
`default_nettype none

module mcmc_step_size_bisection_tuner
	import mcmc_sst_pkg::*;
#(
	parameter int PARAM_COUNT = 4,
	parameter int COUNT_BITS  = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        mode,
	input  wire logic [1:0]  param_index,
	input  wire logic        accepted,
	input  wire logic [31:0] start_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [1:0]  param_out,
	output logic      [31:0] step_size,
	output logic      [1:0]  tune_stage,
	output logic             step_changed,
	output logic             step_saturated
);

	localparam int PW    = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
	localparam int DEPTH = 2 ** PW;
	localparam int CMP_W = (COUNT_BITS > 24) ? COUNT_BITS : 24;

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_LOAD = 2'd1;
	localparam logic [1:0] T_WAIT = 2'd2;
	localparam logic [1:0] T_OUT  = 2'd3;

	// configuration
	logic [15:0] target_q [NUM_TARGETS];
	logic [15:0] coeff_q;
	logic [23:0] min_trials_q;

	// per-parameter state
	logic [31:0]           step_q   [DEPTH];
	logic [31:0]           low_q    [DEPTH];
	logic [31:0]           high_q   [DEPTH];
	logic [1:0]            stage_q  [DEPTH];
	logic [COUNT_BITS-1:0] acc_t_q  [DEPTH];
	logic [COUNT_BITS-1:0] trial_t_q[DEPTH];

	logic [1:0]  state_q;
	logic        mode_q;
	logic [1:0]  pidx_q;
	logic        acc_in_q;
	logic [31:0] start_q;

	logic [31:0] res_step_q;
	logic [1:0]  res_stage_q;
	logic        res_chg_q;
	logic        res_sat_q;

	logic        out_valid_q;
	logic [1:0]  param_out_q;
	logic [31:0] step_size_q;
	logic [1:0]  tune_stage_q;
	logic        step_changed_q;
	logic        step_sat_q;

	logic [PW-1:0]         pi;
	logic                  p_ok;
	logic [COUNT_BITS-1:0] trial_nxt;
	logic [COUNT_BITS-1:0] acc_nxt;
	core_req_t             core_req;
	core_res_t             core_res;

	logic [31:0] s_cur;
	logic [1:0]  st_cur;
	logic [32:0] mid_sum;
	logic [31:0] mid;
	logic [31:0] dbl;
	logic        stop;
	logic        wr_low;
	logic        wr_high;
	logic        chg;
	logic        sat;
	logic [31:0] new_step;
	logic [1:0]  new_stage;
	logic        out_free;

	assign pi   = pidx_q[PW-1:0];
	assign p_ok = {1'b0, pidx_q} < 3'(PARAM_COUNT);

	// saturating tallies
	assign trial_nxt = (trial_t_q[pi] == '1) ? trial_t_q[pi] : trial_t_q[pi] + 1'b1;
	assign acc_nxt   = (acc_in_q && acc_t_q[pi] != '1) ? acc_t_q[pi] + 1'b1 : acc_t_q[pi];

	assign core_req.start   = (state_q == T_LOAD) && p_ok && (mode_q == MODE_TRIAL);
	assign core_req.n       = 32'(trial_nxt);
	assign core_req.accepts = 32'(acc_nxt);
	assign core_req.target  = target_q[pidx_q];
	assign core_req.coeff   = coeff_q;

	mcmc_sst_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (core_req),
		.res    (core_res)
	);

	// stage rule
	assign s_cur   = step_q[pi];
	assign st_cur  = stage_q[pi];
	// raising the low bound pairs the step with high; lowering the high bound with low
	assign mid_sum = {1'b0, s_cur} + {1'b0, core_res.below ? high_q[pi] : low_q[pi]};
	assign mid     = mid_sum[32:1];
	assign dbl     = s_cur[31] ? 32'hFFFF_FFFF : {s_cur[30:0], 1'b0};
	assign stop    = CMP_W'(trial_t_q[pi]) > CMP_W'(min_trials_q);

	always_comb begin
		wr_low    = 1'b0;
		wr_high   = 1'b0;
		chg       = 1'b0;
		sat       = 1'b0;
		new_step  = s_cur;
		new_stage = st_cur;
		if (st_cur == STAGE_SEARCH) begin
			if (core_res.below) begin
				wr_low    = 1'b1;
				new_step  = mid;
				new_stage = STAGE_BISECT;
				chg       = 1'b1;
			end else if (core_res.above) begin
				wr_high  = 1'b1;
				new_step = dbl;
				sat      = s_cur[31];
				chg      = 1'b1;
			end
		end else if (st_cur == STAGE_BISECT) begin
			if (core_res.below) begin
				wr_low   = 1'b1;
				new_step = mid;
				chg      = 1'b1;
			end else if (core_res.above) begin
				wr_high  = 1'b1;
				new_step = mid;
				chg      = 1'b1;
			end else if (stop) begin
				new_stage = STAGE_DONE;
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == T_IDLE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TARGETS; i++) target_q[i] <= TARGET_RST;
			coeff_q      <= ERROR_COEF_RST;
			min_trials_q <= MIN_TRIALS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET_P0:  target_q[0]  <= cfg_data[15:0];
				REG_TARGET_P1:  target_q[1]  <= cfg_data[15:0];
				REG_TARGET_P2:  target_q[2]  <= cfg_data[15:0];
				REG_TARGET_P3:  target_q[3]  <= cfg_data[15:0];
				REG_ERROR_COEF: coeff_q      <= cfg_data[15:0];
				REG_MIN_TRIALS: min_trials_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				T_IDLE: if (in_valid) state_q <= T_LOAD;
				T_LOAD: state_q <= core_req.start ? T_WAIT : T_OUT;
				T_WAIT: if (core_res.done) state_q <= T_OUT;
				T_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// parameter state with known reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				step_q[i]    <= '0;
				high_q[i]    <= '0;
				stage_q[i]   <= STAGE_SEARCH;
				acc_t_q[i]   <= '0;
				trial_t_q[i] <= '0;
			end
		end else if (state_q == T_LOAD && p_ok) begin
			if (mode_q == MODE_RESTART) begin
				step_q[pi]    <= start_q;
				high_q[pi]    <= '0;
				stage_q[pi]   <= STAGE_SEARCH;
				acc_t_q[pi]   <= '0;
				trial_t_q[pi] <= '0;
			end else begin
				acc_t_q[pi]   <= acc_nxt;
				trial_t_q[pi] <= trial_nxt;
			end
		end else if (state_q == T_WAIT && core_res.done) begin
			step_q[pi]  <= new_step;
			stage_q[pi] <= new_stage;
			if (wr_high) high_q[pi] <= s_cur;
			if (chg) begin
				acc_t_q[pi]   <= '0;
				trial_t_q[pi] <= '0;
			end
		end
	end

	// low bound is read only after it has been written
	always_ff @(posedge clk) begin
		if (state_q == T_WAIT && core_res.done && wr_low) low_q[pi] <= s_cur;
	end

	// transaction capture, result and output payload
	always_ff @(posedge clk) begin
		if (state_q == T_IDLE && in_valid) begin
			mode_q   <= mode;
			pidx_q   <= param_index;
			acc_in_q <= accepted;
			start_q  <= start_value;
		end
		if (state_q == T_LOAD) begin
			res_sat_q <= 1'b0;
			if (!p_ok) begin
				res_step_q  <= '0;
				res_stage_q <= STAGE_SEARCH;
				res_chg_q   <= 1'b0;
			end else begin
				res_step_q  <= start_q;
				res_stage_q <= STAGE_SEARCH;
				res_chg_q   <= 1'b1;
			end
		end
		if (state_q == T_WAIT && core_res.done) begin
			res_step_q  <= new_step;
			res_stage_q <= new_stage;
			res_chg_q   <= chg;
			res_sat_q   <= sat;
		end
		if (state_q == T_OUT && out_free) begin
			param_out_q    <= pidx_q;
			step_size_q    <= res_step_q;
			tune_stage_q   <= res_stage_q;
			step_changed_q <= res_chg_q;
			step_sat_q     <= res_sat_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign param_out      = param_out_q;
	assign step_size      = step_size_q;
	assign tune_stage     = tune_stage_q;
	assign step_changed   = step_changed_q;
	assign step_saturated = step_sat_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		core_res.done |-> state_q == T_WAIT)
		else $error("significance verdict outside wait step");

	a_sat_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && step_saturated) |->
		(step_size == 32'hFFFF_FFFF && tune_stage == STAGE_SEARCH && step_changed))
		else $error("saturated result not a full-scale search step");

	a_bad_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ({1'b0, param_out} >= 3'(PARAM_COUNT))) |->
		(step_size == '0 && tune_stage == STAGE_SEARCH && !step_changed && !step_saturated))
		else $error("out-of-range parameter produced a non-zero result");

endmodule

`default_nettype wire

[rtl/mcmc_sst_mul.sv]
// Shared 32 x 32 unsigned multiplier with registered product.
`default_nettype none

module mcmc_sst_mul (
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] prod
);

	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= {32'h0, a} * {32'h0, b};
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

[rtl/mcmc_sst_core.sv]
// Significance test: exact compare of (T*n - a*2^16)^2 against C^2*256*n on one shared multiplier.
`default_nettype none

module mcmc_sst_core
	import mcmc_sst_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire core_req_t req,
	output core_res_t      res
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TN   = 4'd1;
	localparam logic [3:0] S_CC   = 4'd2;
	localparam logic [3:0] S_RHS  = 4'd3;
	localparam logic [3:0] S_LL   = 4'd4;
	localparam logic [3:0] S_LH   = 4'd5;
	localparam logic [3:0] S_HH   = 4'd6;
	localparam logic [3:0] S_CMP  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0]  seq_q;
	logic [31:0] n_q;
	logic [47:0] an_q;
	logic [15:0] tgt_q;
	logic [15:0] coef_q;
	logic        gt_q;
	logic        lt_q;
	logic [47:0] mag_q;
	logic [71:0] rhs_q;
	logic [95:0] acc_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [47:0] tn;
	logic        big;

	mcmc_sst_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign tn = prod[47:0];

	// operand select per step; the product is registered and shows up in the next cycle
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (seq_q)
			S_TN: begin
				mul_a = {16'h0, tgt_q};
				mul_b = n_q;
			end
			S_CC: begin
				mul_a = {16'h0, coef_q};
				mul_b = {16'h0, coef_q};
			end
			S_RHS: begin
				mul_a = prod[31:0];
				mul_b = n_q;
			end
			S_LL: begin
				mul_a = mag_q[31:0];
				mul_b = mag_q[31:0];
			end
			S_LH: begin
				mul_a = mag_q[31:0];
				mul_b = {16'h0, mag_q[47:32]};
			end
			S_HH: begin
				mul_a = {16'h0, mag_q[47:32]};
				mul_b = {16'h0, mag_q[47:32]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= S_IDLE;
		end else begin
			unique case (seq_q)
				S_IDLE: if (req.start) seq_q <= S_TN;
				S_TN:   seq_q <= S_CC;
				S_CC:   seq_q <= S_RHS;
				S_RHS:  seq_q <= S_LL;
				S_LL:   seq_q <= S_LH;
				S_LH:   seq_q <= S_HH;
				S_HH:   seq_q <= S_CMP;
				S_CMP:  seq_q <= S_DONE;
				S_DONE: seq_q <= S_IDLE;
				default: seq_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (seq_q)
			S_IDLE: begin
				n_q    <= req.n;
				an_q   <= {req.accepts, 16'h0};
				tgt_q  <= req.target;
				coef_q <= req.coeff;
			end
			S_CC: begin
				gt_q  <= tn > an_q;
				lt_q  <= an_q > tn;
				mag_q <= (tn > an_q) ? (tn - an_q) : (an_q - tn);
			end
			S_LL: rhs_q <= {prod, 8'h0};
			S_LH: acc_q <= {32'h0, prod};
			// cross term counted twice: ml*mh << 33
			S_HH: acc_q <= acc_q + {prod[62:0], 33'h0};
			S_CMP: acc_q <= acc_q + {prod[31:0], 64'h0};
			default: ;
		endcase
	end

	assign big       = acc_q > {24'h0, rhs_q};
	assign res.done  = (seq_q == S_DONE);
	assign res.below = gt_q & big;
	assign res.above = lt_q & big;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> seq_q == S_IDLE)
		else $error("significance unit started while busy");

	a_fixed_len: assert property (@(posedge clk) disable iff (!arst_n)
		(req.start && seq_q == S_IDLE) |-> ##8 res.done)
		else $error("significance verdict not eight cycles after start");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> !(res.below && res.above))
		else $error("acceptance both above and below target");

endmodule

`default_nettype wire
